@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// Shared concurrent assertion macros for the line period monitor
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define LPM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/lpm_pkg.sv @@
// ----------------------------------------------------------------------------
// lpm_pkg
// Widths, codes and shared types of the line period monitor
// ----------------------------------------------------------------------------
package lpm_pkg;

    // field and datapath widths
    localparam int TIMER_WIDTH = 32;
    localparam int PERIOD_W    = 32;
    localparam int FREQ_W      = 20;
    localparam int CNT_W       = 32;
    localparam int SUM_W       = 64;
    localparam int PROD_W      = TIMER_WIDTH + FREQ_W;
    localparam int DIV_DW      = 64;
    localparam int DIV_SW      = 32;
    localparam int STEP_W      = $clog2(DIV_DW + 1);
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CMD_W       = 2;
    localparam int CAP_W       = 32;
    localparam int EXP_W       = 6;
    localparam int TOL_W       = 9;

    // microseconds per second, also the frequency numerator
    localparam logic [FREQ_W-1:0] US_PER_S = FREQ_W'(1000000);

    // request commands
    localparam logic [CMD_W-1:0] CMD_CAPTURE     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TRACK_RESET = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STATS_RESET = 2'd2;

    // result status codes
    localparam logic ST_OK       = 1'b0;
    localparam logic ST_REJECTED = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMER_CLK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_HZ    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOL       = 2'd2;

    // divider request and response
    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_SW-1:0] divisor;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_DW-1:0] quotient;
    } div_rsp_t;

endpackage

@@ rtl/core/lpm_divider.sv @@
// ----------------------------------------------------------------------------
// lpm_divider
// Shared restoring divider, one quotient bit per cycle. The dividend is
// left aligned so that only the requested number of steps is run.
// ----------------------------------------------------------------------------
module lpm_divider
    import lpm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DIV_SW-1:0] rem_reg;
    logic [DIV_DW-1:0] quo_reg;
    logic [DIV_SW-1:0] dvs_reg;

    logic [DIV_SW:0]   trial;
    logic              fits;
    logic [DIV_SW:0]   diff;

    // trial subtract of one step
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_DW-1]};
        fits  = (trial >= {1'b0, dvs_reg});
        diff  = trial - {1'b0, dvs_reg};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIV_SW-1:0] : trial[DIV_SW-1:0];
            quo_reg <= {quo_reg[DIV_DW-2:0], fits};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ rtl/core/line_period_monitor_top.sv @@
// ----------------------------------------------------------------------------
// line_period_monitor_top
// A valid crossing runs a multiply, then divisions of 52, 20, 64 and 20
// steps on the shared divider; an out of band crossing runs only the first
// two divisions, a zero period only the first, other requests none. A new
// request is taken only once the last result is loaded into the output register.
// Reset clears all tracking and statistics and loads the default registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module line_period_monitor_top
    import lpm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [CAP_W-1:0]     capture_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 status,
    output logic                 measured,
    output logic [PERIOD_W-1:0]  line_period,
    output logic [FREQ_W-1:0]    line_freq,
    output logic                 freq_in_band,
    output logic [CNT_W-1:0]     crossing_count,
    output logic [CNT_W-1:0]     total_count,
    output logic [CNT_W-1:0]     valid_count,
    output logic [PERIOD_W-1:0]  min_period,
    output logic [PERIOD_W-1:0]  max_period,
    output logic [PERIOD_W-1:0]  avg_period,
    output logic [FREQ_W-1:0]    avg_frequency
);

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MUL     = 4'd1;
    localparam logic [3:0] S_US_GO   = 4'd2;
    localparam logic [3:0] S_US_WAIT = 4'd3;
    localparam logic [3:0] S_F_GO    = 4'd4;
    localparam logic [3:0] S_F_WAIT  = 4'd5;
    localparam logic [3:0] S_UPD     = 4'd6;
    localparam logic [3:0] S_M_GO    = 4'd7;
    localparam logic [3:0] S_M_WAIT  = 4'd8;
    localparam logic [3:0] S_FM_GO   = 4'd9;
    localparam logic [3:0] S_FM_WAIT = 4'd10;
    localparam logic [3:0] S_DONE    = 4'd11;

    logic [3:0]             state_reg, state_next;

    logic [DIV_SW-1:0]      timer_clk_reg;
    logic [EXP_W-1:0]       exp_hz_reg;
    logic [TOL_W-1:0]       tol_reg;

    logic [TIMER_WIDTH-1:0] prev_reg, prev_next;
    logic [TIMER_WIDTH-1:0] ticks_reg, ticks_next;
    logic [PROD_W-1:0]      prod_reg;
    logic                   status_reg, status_next;
    logic                   meas_reg, meas_next;
    logic [PERIOD_W-1:0]    last_period_reg, last_period_next;
    logic [FREQ_W-1:0]      last_freq_reg, last_freq_next;
    logic                   last_valid_reg, last_valid_next;
    logic [CNT_W-1:0]       crossings_reg, crossings_next;
    logic [CNT_W-1:0]       total_seen_reg, total_seen_next;
    logic [CNT_W-1:0]       valid_seen_reg, valid_seen_next;
    logic [PERIOD_W-1:0]    period_min_reg, period_min_next;
    logic [PERIOD_W-1:0]    period_max_reg, period_max_next;
    logic [SUM_W-1:0]       period_sum_reg, period_sum_next;
    logic [CNT_W-1:0]       samples_reg, samples_next;
    logic [PERIOD_W-1:0]    mean_reg, mean_next;
    logic [FREQ_W-1:0]      freq_mean_reg, freq_mean_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   load;

    div_req_t               div_req;
    div_rsp_t               div_rsp;

    logic [TIMER_WIDTH-1:0] cap_low;
    logic                   accept;
    logic [PERIOD_W-1:0]    period_sat;
    logic [FREQ_W-1:0]      freq_diff;
    logic [29:0]            dev_scaled;
    logic [TOL_W+EXP_W-1:0] dev_limit;
    logic                   freq_ok;
    logic [CNT_W-1:0]       samples_inc;
    logic                   min_seen;

    assign cap_low  = capture_value[TIMER_WIDTH-1:0];
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign load     = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // shared divider
    lpm_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // saturate the microsecond quotient to the period width
    assign period_sat = (|div_rsp.quotient[DIV_DW-1:PERIOD_W])
                        ? '1 : div_rsp.quotient[PERIOD_W-1:0];

    // tolerance check on the latest frequency
    always_comb
    begin
        freq_diff  = (last_freq_reg > FREQ_W'(exp_hz_reg))
                     ? last_freq_reg - FREQ_W'(exp_hz_reg)
                     : FREQ_W'(exp_hz_reg) - last_freq_reg;
        dev_scaled = 30'(freq_diff) * 30'd1000;
        dev_limit  = (TOL_W+EXP_W)'(tol_reg) * (TOL_W+EXP_W)'(exp_hz_reg);
        freq_ok    = (last_freq_reg != '0) && (exp_hz_reg != '0)
                     && (dev_scaled <= 30'(dev_limit));
    end

    assign samples_inc = samples_reg + 1'b1;

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        prev_next        = prev_reg;
        ticks_next       = ticks_reg;
        status_next      = status_reg;
        meas_next        = meas_reg;
        last_period_next = last_period_reg;
        last_freq_next   = last_freq_reg;
        last_valid_next  = last_valid_reg;
        crossings_next   = crossings_reg;
        total_seen_next  = total_seen_reg;
        valid_seen_next  = valid_seen_reg;
        period_min_next  = period_min_reg;
        period_max_next  = period_max_reg;
        period_sum_next  = period_sum_reg;
        samples_next     = samples_reg;
        mean_next        = mean_reg;
        freq_mean_next   = freq_mean_reg;
        div_req          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = ST_OK;
                    meas_next   = 1'b0;
                    state_next  = S_DONE;
                    unique case (cmd)
                        CMD_CAPTURE:
                        begin
                            if ((cap_low == '0) || (timer_clk_reg == '0))
                            begin
                                status_next = ST_REJECTED;
                            end
                            else
                            begin
                                prev_next = cap_low;
                                if (prev_reg != '0)
                                begin
                                    ticks_next = cap_low - prev_reg;
                                    meas_next  = 1'b1;
                                    state_next = S_MUL;
                                end
                            end
                        end
                        CMD_TRACK_RESET:
                        begin
                            prev_next       = '0;
                            crossings_next  = '0;
                            last_valid_next = 1'b0;
                        end
                        CMD_STATS_RESET:
                        begin
                            total_seen_next = '0;
                            valid_seen_next = '0;
                            period_min_next = '0;
                            period_max_next = '0;
                            period_sum_next = '0;
                            samples_next    = '0;
                            mean_next       = '0;
                            freq_mean_next  = '0;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                state_next = S_US_GO;
            end
            S_US_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {prod_reg, (DIV_DW-PROD_W)'(0)};
                div_req.divisor  = timer_clk_reg;
                div_req.steps    = STEP_W'(PROD_W);
                state_next       = S_US_WAIT;
            end
            S_US_WAIT:
            begin
                if (div_rsp.done)
                begin
                    last_period_next = period_sat;
                    last_freq_next   = '0;
                    state_next       = (period_sat == '0) ? S_UPD : S_F_GO;
                end
            end
            S_F_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {US_PER_S, (DIV_DW-FREQ_W)'(0)};
                div_req.divisor  = DIV_SW'(last_period_reg);
                div_req.steps    = STEP_W'(FREQ_W);
                state_next       = S_F_WAIT;
            end
            S_F_WAIT:
            begin
                if (div_rsp.done)
                begin
                    last_freq_next = div_rsp.quotient[FREQ_W-1:0];
                    state_next     = S_UPD;
                end
            end
            S_UPD:
            begin
                last_valid_next = freq_ok;
                crossings_next  = crossings_reg + 1'b1;
                total_seen_next = total_seen_reg + 1'b1;
                state_next      = S_DONE;
                if (freq_ok)
                begin
                    valid_seen_next = valid_seen_reg + 1'b1;
                    if ((period_min_reg == '0) || (last_period_reg < period_min_reg))
                    begin
                        period_min_next = last_period_reg;
                    end
                    if (last_period_reg > period_max_reg)
                    begin
                        period_max_next = last_period_reg;
                    end
                    period_sum_next = period_sum_reg + SUM_W'(last_period_reg);
                    samples_next    = samples_inc;
                    if (samples_inc != '0)
                    begin
                        state_next = S_M_GO;
                    end
                end
            end
            S_M_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_DW'(period_sum_reg);
                div_req.divisor  = DIV_SW'(samples_reg);
                div_req.steps    = STEP_W'(DIV_DW);
                state_next       = S_M_WAIT;
            end
            S_M_WAIT:
            begin
                if (div_rsp.done)
                begin
                    mean_next = div_rsp.quotient[PERIOD_W-1:0];
                    if (div_rsp.quotient[PERIOD_W-1:0] == '0)
                    begin
                        freq_mean_next = '0;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FM_GO;
                    end
                end
            end
            S_FM_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {US_PER_S, (DIV_DW-FREQ_W)'(0)};
                div_req.divisor  = DIV_SW'(mean_reg);
                div_req.steps    = STEP_W'(FREQ_W);
                state_next       = S_FM_WAIT;
            end
            S_FM_WAIT:
            begin
                if (div_rsp.done)
                begin
                    freq_mean_next = div_rsp.quotient[FREQ_W-1:0];
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // tracking and statistics state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            prev_reg        <= '0;
            status_reg      <= ST_OK;
            meas_reg        <= 1'b0;
            last_period_reg <= '0;
            last_freq_reg   <= '0;
            last_valid_reg  <= 1'b0;
            crossings_reg   <= '0;
            total_seen_reg  <= '0;
            valid_seen_reg  <= '0;
            period_min_reg  <= '0;
            period_max_reg  <= '0;
            period_sum_reg  <= '0;
            samples_reg     <= '0;
            mean_reg        <= '0;
            freq_mean_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            prev_reg        <= prev_next;
            status_reg      <= status_next;
            meas_reg        <= meas_next;
            last_period_reg <= last_period_next;
            last_freq_reg   <= last_freq_next;
            last_valid_reg  <= last_valid_next;
            crossings_reg   <= crossings_next;
            total_seen_reg  <= total_seen_next;
            valid_seen_reg  <= valid_seen_next;
            period_min_reg  <= period_min_next;
            period_max_reg  <= period_max_next;
            period_sum_reg  <= period_sum_next;
            samples_reg     <= samples_next;
            mean_reg        <= mean_next;
            freq_mean_reg   <= freq_mean_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_clk_reg <= DIV_SW'(1000000);
            exp_hz_reg    <= EXP_W'(50);
            tol_reg       <= TOL_W'(50);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TIMER_CLK: timer_clk_reg <= cfg_wdata[DIV_SW-1:0];
                REG_EXP_HZ:    exp_hz_reg    <= cfg_wdata[EXP_W-1:0];
                REG_TOL:       tol_reg       <= cfg_wdata[TOL_W-1:0];
                default:       timer_clk_reg <= timer_clk_reg;
            endcase
        end
    end

    // tick difference and microsecond product
    always_ff @(posedge clk)
    begin
        ticks_reg <= ticks_next;
        if (state_reg == S_MUL)
        begin
            prod_reg <= PROD_W'(ticks_reg) * PROD_W'(US_PER_S);
        end
    end

    // output register
    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status         <= status_reg;
            measured       <= meas_reg;
            line_period    <= last_period_reg;
            line_freq      <= last_freq_reg;
            freq_in_band   <= last_valid_reg;
            crossing_count <= crossings_reg;
            total_count    <= total_seen_reg;
            valid_count    <= valid_seen_reg;
            min_period     <= period_min_reg;
            max_period     <= period_max_reg;
            avg_period     <= mean_reg;
            avg_frequency  <= freq_mean_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign min_seen  = out_valid_reg && (min_period != '0);

    // checks
    `LPM_ASSERT_NEXT(a_busy_after_req, clk, rst_n, accept, !in_ready, "ready after a request")
    `LPM_ASSERT_SAME(a_div_start_idle, clk, rst_n, div_req.start, !div_rsp.busy, "divider busy")
    `LPM_ASSERT_SAME(a_meas_no_error, clk, rst_n, out_valid, !(status && measured), "bad flags")
    `LPM_ASSERT_SAME(a_min_le_max, clk, rst_n, min_seen, min_period <= max_period, "min over max")

endmodule

@@ tb/line_period_monitor_top_tb.sv @@
// ----------------------------------------------------------------------------
// line_period_monitor_top_tb
// Drives capture, tracking reset, statistics reset and unused requests into
// the line period monitor under several register settings and idling patterns.
// A scoreboard predicts every result from its own copy of the period, frequency
// and statistics state and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module line_period_monitor_top_tb
    import lpm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // codes not named in the package
    localparam logic [CMD_W-1:0]     CMD_UNUSED      = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED      = 2'd3;

    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int SETTLE_CYCLES   = 200;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int MAX_PRINTED     = 100;

    localparam longint unsigned US_PER_SECOND = 64'd1000000;

    typedef struct packed {
        logic                status;
        logic                measured;
        logic [PERIOD_W-1:0] line_period;
        logic [FREQ_W-1:0]   line_freq;
        logic                freq_in_band;
        logic [CNT_W-1:0]    crossing_count;
        logic [CNT_W-1:0]    total_count;
        logic [CNT_W-1:0]    valid_count;
        logic [PERIOD_W-1:0] min_period;
        logic [PERIOD_W-1:0] max_period;
        logic [PERIOD_W-1:0] avg_period;
        logic [FREQ_W-1:0]   avg_frequency;
    } line_result_t;

    // ------------------------------------------------------------------------
    // scoreboard: period/frequency predictor and queue of expected results
    // ------------------------------------------------------------------------
    class line_period_scoreboard;
        bit [31:0]          clk_hz;
        bit [EXP_W-1:0]     exp_hz;
        bit [TOL_W-1:0]     tol_tenths;

        bit [CAP_W-1:0]     prev_capture;
        bit [PERIOD_W-1:0]  last_period;
        bit [FREQ_W-1:0]    last_freq;
        bit                 last_valid;
        bit [CNT_W-1:0]     crossings;
        bit [CNT_W-1:0]     total_seen;
        bit [CNT_W-1:0]     valid_seen;
        bit [PERIOD_W-1:0]  period_min;
        bit [PERIOD_W-1:0]  period_max;
        bit [SUM_W-1:0]     period_total;
        bit [CNT_W-1:0]     period_samples;
        bit [PERIOD_W-1:0]  period_mean;
        bit [FREQ_W-1:0]    freq_mean;

        line_result_t       expected_results[$];
        int                 errors;

        function new();
            clk_hz     = 32'd1000000;
            exp_hz     = EXP_W'(50);
            tol_tenths = TOL_W'(50);
            errors     = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_TIMER_CLK: clk_hz     = data;
                REG_EXP_HZ:    exp_hz     = data[EXP_W-1:0];
                REG_TOL:       tol_tenths = data[TOL_W-1:0];
                default: ;
            endcase
        endfunction

        function void clear_statistics();
            total_seen     = '0;
            valid_seen     = '0;
            period_min     = '0;
            period_max     = '0;
            period_total   = '0;
            period_samples = '0;
            period_mean    = '0;
            freq_mean      = '0;
        endfunction

        // exact check of |f - expected| against tolerance in tenths of a percent
        function bit in_band(bit [31:0] freq);
            bit [63:0] diff;
            if (freq == 0 || exp_hz == 0)
                return 1'b0;
            diff = (freq > exp_hz) ? 64'(freq - exp_hz) : 64'(exp_hz - freq);
            return (diff * 64'd1000) <= (64'(tol_tenths) * 64'(exp_hz));
        endfunction

        // period from tick difference, then frequency and statistics
        function void take_period(bit [CAP_W-1:0] cap);
            bit [TIMER_WIDTH-1:0] ticks;
            bit [63:0]            us;
            bit [PERIOD_W-1:0]    period;
            bit [31:0]            freq;
            bit                   ok;
            ticks  = TIMER_WIDTH'(cap - prev_capture);
            us     = (64'(ticks) * US_PER_SECOND) / 64'(clk_hz);
            period = (us > 64'hFFFF_FFFF) ? '1 : us[PERIOD_W-1:0];
            freq   = (period == 0) ? 32'd0 : 32'(US_PER_SECOND / 64'(period));
            ok     = in_band(freq);

            last_period = period;
            last_freq   = freq[FREQ_W-1:0];
            last_valid  = ok;
            crossings++;
            total_seen++;
            if (ok)
            begin
                valid_seen++;
                if (period_min == 0 || period < period_min)
                    period_min = period;
                if (period > period_max)
                    period_max = period;
                period_total += 64'(period);
                period_samples++;
                // a wrapped sample counter keeps the old means
                if (period_samples != 0)
                begin
                    period_mean = PERIOD_W'(period_total / 64'(period_samples));
                    freq_mean   = (period_mean == 0) ? '0 :
                                  FREQ_W'(US_PER_SECOND / 64'(period_mean));
                end
            end
        endfunction

        function void note_request(logic [CMD_W-1:0] req_cmd, logic [CAP_W-1:0] req_cap);
            line_result_t   r;
            bit [CAP_W-1:0] cap;
            bit             st;
            bit             meas;
            cap  = req_cap & CAP_W'((64'd1 << TIMER_WIDTH) - 1);
            st   = ST_OK;
            meas = 1'b0;
            case (req_cmd)
                CMD_CAPTURE:
                begin
                    if (cap == 0 || clk_hz == 0)
                        st = ST_REJECTED;
                    else
                    begin
                        if (prev_capture != 0)
                        begin
                            take_period(cap);
                            meas = 1'b1;
                        end
                        prev_capture = cap;
                    end
                end
                CMD_TRACK_RESET:
                begin
                    prev_capture = '0;
                    crossings    = '0;
                    last_valid   = 1'b0;
                end
                CMD_STATS_RESET: clear_statistics();
                default: ;
            endcase

            r.status         = st;
            r.measured       = meas;
            r.line_period    = last_period;
            r.line_freq      = last_freq;
            r.freq_in_band   = last_valid;
            r.crossing_count = crossings;
            r.total_count    = total_seen;
            r.valid_count    = valid_seen;
            r.min_period     = period_min;
            r.max_period     = period_max;
            r.avg_period     = period_mean;
            r.avg_frequency  = freq_mean;
            expected_results.push_back(r);
        endfunction

        task report_mismatch(string what);
            if (errors < MAX_PRINTED)
                $display("%0t ns: result error: %s", $time, what);
            errors++;
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, want));
        endtask

        task check_result(line_result_t got);
            line_result_t want;
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with no request outstanding");
                return;
            end
            want = expected_results.pop_front();
            compare_field("status",         got.status,         want.status);
            compare_field("measured",       got.measured,       want.measured);
            compare_field("line_period",    got.line_period,    want.line_period);
            compare_field("line_freq",      got.line_freq,      want.line_freq);
            compare_field("freq_in_band",   got.freq_in_band,   want.freq_in_band);
            compare_field("crossing_count", got.crossing_count, want.crossing_count);
            compare_field("total_count",    got.total_count,    want.total_count);
            compare_field("valid_count",    got.valid_count,    want.valid_count);
            compare_field("min_period",     got.min_period,     want.min_period);
            compare_field("max_period",     got.max_period,     want.max_period);
            compare_field("avg_period",     got.avg_period,     want.avg_period);
            compare_field("avg_frequency",  got.avg_frequency,  want.avg_frequency);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // signals and block under test
    // ------------------------------------------------------------------------
    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]     cfg_wdata     = '0;
    logic                 in_valid      = 1'b0;
    logic                 in_ready;
    logic [CMD_W-1:0]     cmd           = CMD_CAPTURE;
    logic [CAP_W-1:0]     capture_value = '0;
    logic                 out_valid;
    logic                 out_ready     = 1'b0;
    logic                 status;
    logic                 measured;
    logic [PERIOD_W-1:0]  line_period;
    logic [FREQ_W-1:0]    line_freq;
    logic                 freq_in_band;
    logic [CNT_W-1:0]     crossing_count;
    logic [CNT_W-1:0]     total_count;
    logic [CNT_W-1:0]     valid_count;
    logic [PERIOD_W-1:0]  min_period;
    logic [PERIOD_W-1:0]  max_period;
    logic [PERIOD_W-1:0]  avg_period;
    logic [FREQ_W-1:0]    avg_frequency;

    line_period_scoreboard sb;
    int                    sender_idle_pct    = 0;
    int                    receiver_stall_pct = 0;
    int                    quiet_cycles       = 0;
    logic [CAP_W-1:0]      line_time          = 32'd1;

    line_period_monitor_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .capture_value  (capture_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .measured       (measured),
        .line_period    (line_period),
        .line_freq      (line_freq),
        .freq_in_band   (freq_in_band),
        .crossing_count (crossing_count),
        .total_count    (total_count),
        .valid_count    (valid_count),
        .min_period     (min_period),
        .max_period     (max_period),
        .avg_period     (avg_period),
        .avg_frequency  (avg_frequency)
    );

    // 12 ns clock
    always #6 clk = ~clk;

    // result side back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // handshake monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result('{status: status, measured: measured,
                                  line_period: line_period, line_freq: line_freq,
                                  freq_in_band: freq_in_band,
                                  crossing_count: crossing_count,
                                  total_count: total_count, valid_count: valid_count,
                                  min_period: min_period, max_period: max_period,
                                  avg_period: avg_period, avg_frequency: avg_frequency});
            if (in_valid && in_ready)
                sb.note_request(cmd, capture_value);
            if ((out_valid && out_ready) || (in_valid && in_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // driver tasks, all entered right after a rising edge
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [CMD_W-1:0] req_cmd, input logic [CAP_W-1:0] req_cap);
        int gap;
        gap = 0;
        while (gap < 400 && $urandom_range(0, 99) < sender_idle_pct)
            gap++;
        // occasional long gap so idling lands on later parts of a measurement
        if (sender_idle_pct > 0 && $urandom_range(0, 15) == 0)
            gap += $urandom_range(1, 200);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        cmd           <= req_cmd;
        capture_value <= req_cap;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.set_register(idx, data);
    endtask

    // all registers plus an ignored index, only with nothing in flight
    task automatic configure(input logic [CFG_W-1:0] clk_hz, input logic [CFG_W-1:0] exp_hz,
                             input logic [CFG_W-1:0] tol);
        drain();
        write_register(REG_TIMER_CLK, clk_hz);
        write_register(REG_EXP_HZ, exp_hz);
        write_register(REG_TOL, tol);
        write_register(REG_UNUSED, $urandom());
        cfg_we <= 1'b0;
    endtask

    // ticks for one mains period near nominal, jittered around the tolerance band
    function automatic logic [CAP_W-1:0] line_ticks();
        longint nominal;
        longint span;
        longint dev;
        longint period;
        longint ticks;
        nominal = (sb.exp_hz == 0) ? 20000 : 1000000 / sb.exp_hz;
        span    = longint'(sb.tol_tenths) + 30;
        dev     = longint'($urandom_range(0, 32'(2 * span))) - span;
        period  = nominal + (nominal * dev) / 1000;
        ticks   = (period * longint'({32'd0, sb.clk_hz})) / 1000000
                  + longint'($urandom_range(0, 2));
        return ticks[CAP_W-1:0];
    endfunction

    task automatic run_random_items(input int count);
        int             pick;
        logic [CAP_W-1:0] v;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 72)
            begin
                // well-formed crossing
                line_time = line_time + line_ticks();
                if (line_time == 0)
                    line_time = 1;
                send_request(CMD_CAPTURE, line_time);
            end
            else if (pick < 78)
            begin
                // off-band period of random magnitude
                line_time = line_time + ($urandom() >> $urandom_range(0, 31));
                if (line_time == 0)
                    line_time = 1;
                send_request(CMD_CAPTURE, line_time);
            end
            else if (pick < 82)
            begin
                v = $urandom();
                if (v != 0)
                    line_time = v;
                send_request(CMD_CAPTURE, v);
            end
            else if (pick < 85)
                send_request(CMD_CAPTURE, '0);
            else if (pick < 88)
                send_request(CMD_CAPTURE, line_time);
            else if (pick < 92)
                send_request(CMD_TRACK_RESET, $urandom());
            else if (pick < 95)
                send_request(CMD_STATS_RESET, $urandom());
            else if (pick < 97)
                send_request(CMD_UNUSED, $urandom());
            else
            begin
                // very short period
                line_time = line_time + $urandom_range(1, 3);
                if (line_time == 0)
                    line_time = 1;
                send_request(CMD_CAPTURE, line_time);
            end
            // occasionally the sender holds off until every result is back
            if ($urandom_range(0, 59) == 0)
                drain();
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default registers: zero capture, seed, nominal, equal, wrap, unused command, resets
        send_request(CMD_CAPTURE, 32'd0);
        send_request(CMD_CAPTURE, 32'd1000);
        send_request(CMD_CAPTURE, 32'd21000);
        send_request(CMD_CAPTURE, 32'd21000);
        send_request(CMD_CAPTURE, 32'd41400);
        send_request(CMD_CAPTURE, 32'd41401);
        send_request(CMD_CAPTURE, 32'hFFFF_FFF0);
        send_request(CMD_CAPTURE, 32'd19984);
        send_request(CMD_UNUSED, 32'hFFFF_FFFF);
        send_request(CMD_CAPTURE, 32'd0);
        send_request(CMD_STATS_RESET, 32'hFFFF_FFFF);
        send_request(CMD_CAPTURE, 32'd39984);
        send_request(CMD_TRACK_RESET, 32'h5555_AAAA);
        send_request(CMD_CAPTURE, 32'hFFFF_FFFF);

        // slowest timer: saturated period, then a one hertz frequency
        configure(32'd1, 32'd60, 32'd0);
        send_request(CMD_CAPTURE, 32'd5000);
        send_request(CMD_CAPTURE, 32'd5001);

        // stopped timer rejects captures
        configure(32'd0, 32'd60, 32'd0);
        send_request(CMD_CAPTURE, 32'd100);

        // zero tolerance: exact match passes, one hertz off fails
        configure(32'd6000000, 32'd60, 32'd0);
        send_request(CMD_CAPTURE, 32'd104997);
        send_request(CMD_CAPTURE, 32'd204999);

        // no expected frequency, widest tolerance with extra data bits
        configure(32'd6000000, 32'd0, 32'h0000_FFFF);
        send_request(CMD_CAPTURE, 32'd304999);

        line_time = 32'd304999;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: configure(32'd1000000,    32'd50, 32'd50);
                1: configure(32'hFFFF_FFFF,  32'd60, 32'd500);
                2: configure(32'd32768,      32'd50, 32'd1);
                3: configure(32'd1000000,    32'd63, 32'd511);
                4: configure(32'd16000000,   32'd60, 32'd0);
                5: configure(32'd1,          32'd50, 32'd50);
                6: configure(32'd12000000,   32'd0,  32'd200);
                default: configure(32'd1000000, 32'd55, 32'd100);
            endcase
            case (p % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 78;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 78;
                end
                default:
                begin
                    sender_idle_pct    = 13;
                    receiver_stall_pct = 13;
                end
            endcase
            // fewer items where the timer setting makes everything degenerate
            run_random_items((p == 5) ? ITEMS_PER_PHASE / 3 : ITEMS_PER_PHASE);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
